FILE: hdl/assert_macros.svh
// Assertion macros shared by the text to integer converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SDTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SDTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sdti_pkg.sv
// Types and constants of the decimal text to 64-bit integer converter.
`default_nettype none

package sdti_pkg;

  localparam int CHAR_W = 8;
  localparam int MAG_W  = 63;
  localparam int VAL_W  = 64;
  localparam int PROD_W = MAG_W + 4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_FAIL   = 3'd4
  } phase_t;

endpackage

`default_nettype wire

FILE: hdl/sdti_in_if.sv
// Input channel carrying at most one text byte per beat.
`default_nettype none

interface sdti_in_if
  import sdti_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CHAR_W-1:0]        char_code;
  logic                     has_char;
  logic                     last_char;
  logic signed [VAL_W-1:0]  fallback_value;

  modport source (output valid, output char_code, output has_char, output last_char,
                  output fallback_value, input ready);
  modport sink (input valid, input char_code, input has_char, input last_char,
                input fallback_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/sdti_out_if.sv
// Result channel carrying one parsed integer per beat.
`default_nettype none

interface sdti_out_if
  import sdti_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  parsed_value;
  logic                     used_fallback;

  modport source (output valid, output parsed_value, output used_fallback, input ready);
  modport sink (input valid, input parsed_value, input used_fallback, output ready);
endinterface

`default_nettype wire

FILE: hdl/strict_decimal_text_to_int64.sv
// A result beat passes the input buffer register and then the output register.
// Throughput: one input beat per cycle (multiply-by-ten is combinational) unless an ending beat waits on a busy output.
// The output register lets a new beat enter while a finished result waits.
// Reset (synchronous, active low) empties both registers and returns the parser
// to the leading-blank phase with a zero magnitude.
`default_nettype none

module strict_decimal_text_to_int64
  import sdti_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  sdti_in_if.sink    in_ch,
  sdti_out_if.source out_ch
);

  `include "assert_macros.svh"

  logic                    s1_valid_r;
  logic [CHAR_W-1:0]       s1_char_r;
  logic                    s1_has_r;
  logic                    s1_last_r;
  logic signed [VAL_W-1:0] s1_fallback_r;

  phase_t                  phase_r, phase_nxt, phase_c;
  logic                    neg_r, neg_nxt, neg_c;
  logic [MAG_W-1:0]        acc_r, acc_nxt, acc_c;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_flag_r, out_flag_nxt;

  logic                    s1_end;
  logic                    s1_adv;
  logic                    out_free;
  logic                    in_fire;
  logic                    is_blank;
  logic                    is_sign;
  logic                    is_digit;
  logic                    take_digit;
  logic [PROD_W-1:0]       prod;
  logic                    ovf;
  logic signed [VAL_W-1:0] result_value;
  logic                    result_flag;

  assign s1_end   = !s1_has_r || s1_last_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && (!s1_end || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign is_blank = (s1_char_r == CH_SPACE) || (s1_char_r == CH_TAB);
  assign is_sign  = (s1_char_r == CH_PLUS) || (s1_char_r == CH_MINUS);
  assign is_digit = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {{(PROD_W-4){1'b0}}, s1_char_r[3:0]};
  assign ovf      = |prod[PROD_W-1:MAG_W];

  // Effect of the buffered byte on the parser state.
  always_comb begin
    phase_c    = phase_r;
    neg_c      = neg_r;
    acc_c      = acc_r;
    take_digit = 1'b0;
    if (s1_has_r) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (is_blank) begin
            phase_c = PH_LEAD;
          end else if (is_sign) begin
            neg_c   = (s1_char_r == CH_MINUS);
            phase_c = PH_SIGNED;
          end else begin
            take_digit = 1'b1;
          end
        end
        PH_SIGNED, PH_DIGITS: begin
          take_digit = 1'b1;
        end
        PH_TRAIL: begin
          if (!is_blank) begin
            phase_c = PH_FAIL;
          end
        end
        default: begin
          phase_c = PH_FAIL;
        end
      endcase
      if (take_digit) begin
        if (is_digit) begin
          if (ovf) begin
            phase_c = PH_FAIL;
          end else begin
            acc_c   = prod[MAG_W-1:0];
            phase_c = PH_DIGITS;
          end
        end else if (phase_r == PH_DIGITS && is_blank) begin
          phase_c = PH_TRAIL;
        end else begin
          phase_c = PH_FAIL;
        end
      end
    end
  end

  // Next state: the parser restarts after every text end.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    if (s1_adv) begin
      if (s1_end) begin
        phase_nxt = PH_LEAD;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else begin
        phase_nxt = phase_c;
        neg_nxt   = neg_c;
        acc_nxt   = acc_c;
      end
    end
  end

  // Result of a text that ends with the buffered beat.
  always_comb begin
    if (phase_c == PH_DIGITS || phase_c == PH_TRAIL) begin
      result_flag = 1'b0;
      if (neg_c) begin
        result_value = VAL_W'(0) - $signed({1'b0, acc_c});
      end else begin
        result_value = $signed({1'b0, acc_c});
      end
    end else begin
      result_flag  = 1'b1;
      result_value = s1_fallback_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_flag_nxt  = out_flag_r;
    if (s1_adv && s1_end) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = result_value;
      out_flag_nxt  = result_flag;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r     <= in_ch.char_code;
      s1_has_r      <= in_ch.has_char;
      s1_last_r     <= in_ch.last_char;
      s1_fallback_r <= in_ch.fallback_value;
    end
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.parsed_value  = out_value_r;
  assign out_ch.used_fallback = out_flag_r;

  `SDTI_ASSERT(a_lead_is_clean, (phase_r == PH_LEAD) |-> (acc_r == '0 && !neg_r), "lead phase with stale state")
  `SDTI_ASSERT(a_signed_no_mag, (phase_r == PH_SIGNED) |-> (acc_r == '0), "magnitude before first digit")
  `SDTI_ASSERT(a_end_restarts, (s1_adv && s1_end) |=> (phase_r == PH_LEAD), "parser did not restart after text end")
  `SDTI_ASSERT(a_end_gives_result, (s1_adv && s1_end) |=> out_valid_r, "text end produced no result")
  `SDTI_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!s1_valid_r && !out_valid_r), "reset left a beat buffered")

endmodule

`default_nettype wire
